// ===== rtl/xds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xds_pkg
// Shared types and constants for the XDS packet reassembler.
// ----------------------------------------------------------------------------
package xds_pkg;

    // Field widths fixed by the interface
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int CLASS_W  = 3;
    localparam int IDX_W    = 6;
    localparam int CSUM_W   = 7;

    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [CLASS_W-1:0]  class_t;
    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [CSUM_W-1:0]   csum_t;

    // Operation codes
    localparam logic OP_PAIR = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Result status codes
    localparam status_t ST_DATA      = 3'd0;
    localparam status_t ST_OPENED    = 3'd1;
    localparam status_t ST_CONTINUED = 3'd2;
    localparam status_t ST_DROPPED   = 3'd3;
    localparam status_t ST_ILLEGAL   = 3'd4;
    localparam status_t ST_NO_OPEN   = 3'd5;
    localparam status_t ST_BAD_SUM   = 3'd6;
    localparam status_t ST_BYTE      = 3'd7;

    // Byte appended to every packet at end
    localparam byte_t END_MARK = 8'h0F;

    // Header of a single-transaction result
    typedef struct packed {
        status_t status;
        class_t  pkt_class;
        byte_t   pkt_type;
    } result_t;

endpackage

// ===== rtl/xds_packet_reassembler.sv =====
`timescale 1ns / 1ps
// A data pair is rejected, found with a full buffer, or stored; a start/continue code
// searches the buffers, one buffer compared per cycle; an end code checks the sum and
// streams a good packet one byte at a time while out_ready is high.
// Throughput: one transaction at a time; in_ready is high only when idle, so the next
// input is taken the cycle after the last result is loaded. Reset: asynchronous; all
// buffers free, no packet selected. Packet storage is not cleared (only written bytes read).
// ----------------------------------------------------------------------------
// xds_packet_reassembler
// Reassembles interleaved XDS packets from caption byte pairs, checks the
// packet checksum and streams good packets out one byte per transaction.
// ----------------------------------------------------------------------------
module xds_packet_reassembler #(
    parameter int NUM_BUFFERS  = 9,
    parameter int PACKET_BYTES = 35
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  operation,
    input  xds_pkg::byte_t        hi_byte,
    input  xds_pkg::byte_t        lo_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output xds_pkg::status_t      status,
    output xds_pkg::class_t       packet_class,
    output xds_pkg::byte_t        packet_type,
    output xds_pkg::byte_t        packet_byte,
    output xds_pkg::idx_t         byte_index,
    output logic                  last
);

    import xds_pkg::*;

    localparam int BUF_W  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int ADDR_W = $clog2(NUM_BUFFERS * PACKET_BYTES);
    localparam logic [BUF_W-1:0] LAST_BUF = BUF_W'(NUM_BUFFERS - 1);

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_SEL    = 4'd2;
    localparam logic [3:0] S_OPEN   = 4'd3;
    localparam logic [3:0] S_ST_HI  = 4'd4;
    localparam logic [3:0] S_ST_LO  = 4'd5;
    localparam logic [3:0] S_END    = 4'd6;
    localparam logic [3:0] S_STREAM = 4'd7;
    localparam logic [3:0] S_RESULT = 4'd8;

    logic [3:0]       state_reg, state_next;

    // Per-buffer descriptors
    logic             buf_busy_reg  [NUM_BUFFERS];
    logic             buf_busy_next [NUM_BUFFERS];
    class_t           buf_class_reg  [NUM_BUFFERS];
    class_t           buf_class_next [NUM_BUFFERS];
    byte_t            buf_type_reg  [NUM_BUFFERS];
    byte_t            buf_type_next [NUM_BUFFERS];
    idx_t             buf_fill_reg  [NUM_BUFFERS];
    idx_t             buf_fill_next [NUM_BUFFERS];
    csum_t            buf_csum_reg  [NUM_BUFFERS];
    csum_t            buf_csum_next [NUM_BUFFERS];

    // Selection and working registers
    logic [BUF_W-1:0] cur_reg, cur_next;
    logic             cur_valid_reg, cur_valid_next;
    byte_t            hi_reg, hi_next;
    byte_t            lo_reg, lo_next;
    class_t           cls_reg, cls_next;
    logic [BUF_W-1:0] scan_idx_reg, scan_idx_next;
    logic             match_reg, match_next;
    logic             free_found_reg, free_found_next;
    logic [BUF_W-1:0] free_idx_reg, free_idx_next;
    result_t          res_reg, res_next;

    // Stream counters
    idx_t             last_idx_reg, last_idx_next;
    idx_t             rd_idx_reg, rd_idx_next;
    idx_t             emit_idx_reg, emit_idx_next;
    logic             rd_done_reg, rd_done_next;
    logic             pend_reg, pend_next;

    // Output register
    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg, out_status_next;
    class_t           out_class_reg, out_class_next;
    byte_t            out_type_reg, out_type_next;
    byte_t            out_byte_reg, out_byte_next;
    idx_t             out_idx_reg, out_idx_next;
    logic             out_last_reg, out_last_next;

    // Descriptor read port and derived values
    logic [BUF_W-1:0] rd_n;
    logic             rd_busy;
    class_t           rd_class;
    byte_t            rd_type;
    idx_t             rd_fill;
    csum_t            rd_csum;
    logic             has_open;
    logic             fill_room;
    idx_t             end_len;
    csum_t            end_sum;
    csum_t            end_cs;
    logic             end_bad;
    logic [3:0]       code_m1;
    logic             out_free;
    logic             load_out;
    logic             issue;
    logic             buf_init;
    logic             buf_store;
    logic             buf_free;

    // Packet storage
    logic [ADDR_W-1:0] base_addr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    byte_t             ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    byte_t             ram_rdata;

    xds_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(NUM_BUFFERS * PACKET_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Single descriptor read port: scan index while searching, else current
    assign rd_n     = (state_reg == S_SCAN) ? scan_idx_reg : cur_reg;
    assign rd_busy  = buf_busy_reg[rd_n];
    assign rd_class = buf_class_reg[rd_n];
    assign rd_type  = buf_type_reg[rd_n];
    assign rd_fill  = buf_fill_reg[rd_n];
    assign rd_csum  = buf_csum_reg[rd_n];
    assign has_open = cur_valid_reg && rd_busy;

    assign base_addr = ADDR_W'(cur_reg) * ADDR_W'(PACKET_BYTES);
    assign fill_room = (8'(rd_fill) + 8'd3) <= 8'(PACKET_BYTES);
    assign code_m1   = hi_byte[3:0] - 4'd1;

    // End of packet: length clamp and checksum over stored bytes plus end mark
    assign end_len = ({1'b0, rd_fill} >= 7'(PACKET_BYTES)) ? idx_t'(PACKET_BYTES - 1)
                                                           : rd_fill;
    assign end_sum = csum_t'(rd_csum + END_MARK[CSUM_W-1:0]);
    assign end_cs  = csum_t'(7'd0 - end_sum);
    assign end_bad = ({1'b0, end_cs} != lo_reg) || (end_len < 6'd2);

    // Stream handshake with the read pipeline
    assign out_free = !out_valid_reg || out_ready;
    assign load_out = (state_reg == S_STREAM) && pend_reg && out_free;
    assign issue    = (state_reg == S_STREAM) && !rd_done_reg && (!pend_reg || load_out);

    assign in_ready = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        cur_valid_next  = cur_valid_reg;
        hi_next         = hi_reg;
        lo_next         = lo_reg;
        cls_next        = cls_reg;
        scan_idx_next   = scan_idx_reg;
        match_next      = match_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        res_next        = res_reg;
        last_idx_next   = last_idx_reg;
        rd_idx_next     = rd_idx_reg;
        emit_idx_next   = emit_idx_reg;
        rd_done_next    = rd_done_reg;
        pend_next       = pend_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_class_next  = out_class_reg;
        out_type_next   = out_type_reg;
        out_byte_next   = out_byte_reg;
        out_idx_next    = out_idx_reg;
        out_last_next   = out_last_reg;

        ram_we    = 1'b0;
        ram_waddr = base_addr;
        ram_wdata = hi_reg;
        ram_re    = issue;
        ram_raddr = base_addr + ADDR_W'(rd_idx_reg);

        buf_init  = 1'b0;
        buf_store = 1'b0;
        buf_free  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    hi_next = hi_byte;
                    lo_next = lo_byte;
                    if (operation == OP_PAIR)
                    begin
                        if (hi_byte inside {[8'h01:8'h0F]})
                        begin
                            cls_next        = code_m1[3:1];
                            scan_idx_next   = '0;
                            match_next      = 1'b0;
                            free_found_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                        else if ((hi_byte inside {[8'h10:8'h1F]}) ||
                                 (lo_byte inside {[8'h01:8'h1F]}))
                        begin
                            res_next   = '{ST_ILLEGAL, '0, '0};
                            state_next = S_RESULT;
                        end
                        else if (!has_open)
                        begin
                            res_next   = '{ST_NO_OPEN, '0, '0};
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            res_next   = '{ST_DATA, rd_class, rd_type};
                            state_next = S_ST_HI;
                        end
                    end
                    else
                    begin
                        if (!has_open)
                        begin
                            cur_valid_next = 1'b0;
                            res_next       = '{ST_NO_OPEN, '0, '0};
                            state_next     = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_END;
                        end
                    end
                end
            end

            // One buffer compared per cycle; first match wins, else first free
            S_SCAN:
            begin
                if (rd_busy && (rd_class == cls_reg) && (rd_type == lo_reg))
                begin
                    match_next = 1'b1;
                    state_next = S_SEL;
                end
                else
                begin
                    if (!rd_busy && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = scan_idx_reg;
                    end
                    if (scan_idx_reg == LAST_BUF)
                    begin
                        state_next = S_SEL;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + BUF_W'(1);
                    end
                end
            end

            S_SEL:
            begin
                if (match_reg)
                begin
                    cur_next       = scan_idx_reg;
                    cur_valid_next = 1'b1;
                    state_next     = S_OPEN;
                end
                else if (free_found_reg)
                begin
                    cur_next       = free_idx_reg;
                    cur_valid_next = 1'b1;
                    state_next     = S_OPEN;
                end
                else
                begin
                    cur_valid_next = 1'b0;
                    res_next       = '{ST_DROPPED, cls_reg, lo_reg};
                    state_next     = S_RESULT;
                end
            end

            // New start, or continue into a free buffer, resets the descriptor
            S_OPEN:
            begin
                buf_init = hi_reg[0] || !match_reg;
                if (!hi_reg[0])
                begin
                    res_next   = '{ST_CONTINUED, cls_reg, lo_reg};
                    state_next = S_RESULT;
                end
                else
                begin
                    res_next   = '{ST_OPENED, cls_reg, lo_reg};
                    state_next = S_ST_HI;
                end
            end

            S_ST_HI:
            begin
                if (fill_room)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = base_addr + ADDR_W'(rd_fill);
                    ram_wdata  = hi_reg;
                    state_next = S_ST_LO;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end

            S_ST_LO:
            begin
                ram_we     = 1'b1;
                ram_waddr  = base_addr + ADDR_W'(rd_fill) + ADDR_W'(1);
                ram_wdata  = lo_reg;
                buf_store  = 1'b1;
                state_next = S_RESULT;
            end

            // Append end mark, check sum, free the buffer either way
            S_END:
            begin
                ram_we         = 1'b1;
                ram_waddr      = base_addr + ADDR_W'(end_len);
                ram_wdata      = END_MARK;
                cur_valid_next = 1'b0;
                buf_free       = 1'b1;
                if (end_bad)
                begin
                    res_next   = '{ST_BAD_SUM, rd_class, rd_type};
                    state_next = S_RESULT;
                end
                else
                begin
                    res_next      = '{ST_BYTE, rd_class, rd_type};
                    last_idx_next = end_len;
                    rd_idx_next   = '0;
                    emit_idx_next = '0;
                    rd_done_next  = 1'b0;
                    pend_next     = 1'b0;
                    state_next    = S_STREAM;
                end
            end

            // One read in flight; read data waits in the RAM until taken
            S_STREAM:
            begin
                if (issue)
                begin
                    if (rd_idx_reg == last_idx_reg)
                    begin
                        rd_done_next = 1'b1;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + idx_t'(1);
                    end
                end
                if (issue)
                begin
                    pend_next = 1'b1;
                end
                else if (load_out)
                begin
                    pend_next = 1'b0;
                end
                if (load_out)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_reg.status;
                    out_class_next  = res_reg.pkt_class;
                    out_type_next   = res_reg.pkt_type;
                    out_byte_next   = ram_rdata;
                    out_idx_next    = emit_idx_reg;
                    out_last_next   = (emit_idx_reg == last_idx_reg);
                    emit_idx_next   = emit_idx_reg + idx_t'(1);
                    if (emit_idx_reg == last_idx_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_reg.status;
                    out_class_next  = res_reg.pkt_class;
                    out_type_next   = res_reg.pkt_type;
                    out_byte_next   = '0;
                    out_idx_next    = '0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Descriptor updates, always at the current buffer
    always_comb
    begin
        buf_busy_next  = buf_busy_reg;
        buf_class_next = buf_class_reg;
        buf_type_next  = buf_type_reg;
        buf_fill_next  = buf_fill_reg;
        buf_csum_next  = buf_csum_reg;
        if (buf_init)
        begin
            buf_busy_next[cur_reg]  = 1'b1;
            buf_class_next[cur_reg] = cls_reg;
            buf_type_next[cur_reg]  = lo_reg;
            buf_fill_next[cur_reg]  = '0;
            buf_csum_next[cur_reg]  = '0;
        end
        else if (buf_store)
        begin
            buf_fill_next[cur_reg] = rd_fill + 6'd2;
            buf_csum_next[cur_reg] = csum_t'(rd_csum + hi_reg[CSUM_W-1:0]
                                             + lo_reg[CSUM_W-1:0]);
        end
        else if (buf_free)
        begin
            buf_busy_next[cur_reg]  = 1'b0;
            buf_class_next[cur_reg] = '0;
            buf_type_next[cur_reg]  = '0;
            buf_fill_next[cur_reg]  = '0;
            buf_csum_next[cur_reg]  = '0;
        end
    end

    // Control and descriptor registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            rd_done_reg   <= 1'b0;
            for (int i = 0; i < NUM_BUFFERS; i++)
            begin
                buf_busy_reg[i]  <= 1'b0;
                buf_class_reg[i] <= '0;
                buf_type_reg[i]  <= '0;
                buf_fill_reg[i]  <= '0;
                buf_csum_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            rd_done_reg   <= rd_done_next;
            buf_busy_reg  <= buf_busy_next;
            buf_class_reg <= buf_class_next;
            buf_type_reg  <= buf_type_next;
            buf_fill_reg  <= buf_fill_next;
            buf_csum_reg  <= buf_csum_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        hi_reg          <= hi_next;
        lo_reg          <= lo_next;
        cls_reg         <= cls_next;
        scan_idx_reg    <= scan_idx_next;
        match_reg       <= match_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        res_reg         <= res_next;
        last_idx_reg    <= last_idx_next;
        rd_idx_reg      <= rd_idx_next;
        emit_idx_reg    <= emit_idx_next;
        out_status_reg  <= out_status_next;
        out_class_reg   <= out_class_next;
        out_type_reg    <= out_type_next;
        out_byte_reg    <= out_byte_next;
        out_idx_reg     <= out_idx_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign packet_class = out_class_reg;
    assign packet_type  = out_type_reg;
    assign packet_byte  = out_byte_reg;
    assign byte_index   = out_idx_reg;
    assign last         = out_last_reg;

endmodule

// ===== rtl/xds_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xds_ram
// Generic single-write, single-read RAM with registered read data. Read data
// holds its value while re is low.
// ----------------------------------------------------------------------------
module xds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 315
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
